// ----- rtl/bdlp_pkg.sv -----
// Package for the button debouncer with long-press detection.
// Holds phase codes, register indexes, widths and the shared structs.
// No dependencies.
package bdlp_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int IO_BITS     = 4;
    localparam int DB_W        = 8;
    localparam int HOLD_W      = 16;
    localparam int CNT_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DB_W-1:0]   DEBOUNCE_RESET = 8'd10;
    localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_PRESS_DB   = 3'd1,
        PH_PRESSED    = 3'd2,
        PH_HELD       = 3'd3,
        PH_RELEASE_DB = 3'd4
    } phase_t;

    typedef struct packed {
        logic [DB_W-1:0]   debounce_ticks;
        logic [HOLD_W-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic press;
        logic hold;
    } btn_ev_t;

endpackage

// ----- rtl/bdlp_in_if.sv -----
// Request channel carrying one scan tick of raw active-low button levels.
// Depends on bdlp_pkg.
interface bdlp_in_if;
    logic                            valid;
    logic                            ready;
    logic [bdlp_pkg::IO_BITS-1:0]    raw_buttons_n;

    modport source (output valid, output raw_buttons_n, input ready);
    modport sink   (input valid, input raw_buttons_n, output ready);
endinterface

// ----- rtl/bdlp_out_if.sv -----
// Request channel carrying the per-tick press and hold event vectors.
// Depends on bdlp_pkg.
interface bdlp_out_if;
    logic                            valid;
    logic                            ready;
    logic [bdlp_pkg::IO_BITS-1:0]    press_events;
    logic [bdlp_pkg::IO_BITS-1:0]    hold_events;

    modport source (output valid, output press_events, output hold_events, input ready);
    modport sink   (input valid, input press_events, input hold_events, output ready);
endinterface

// ----- rtl/bdlp_button.sv -----
// Per-button five-phase debounce and long-press machine with its down-counter.
// Depends on bdlp_pkg.
module bdlp_button (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             released,
    input  bdlp_pkg::cfg_t   cfg,
    output bdlp_pkg::btn_ev_t ev
);

    bdlp_pkg::phase_t                 phase_reg;
    bdlp_pkg::phase_t                 phase_next;
    logic [bdlp_pkg::CNT_W-1:0]       cnt_reg;
    logic [bdlp_pkg::CNT_W-1:0]       cnt_next;
    logic [bdlp_pkg::CNT_W-1:0]       cnt_dec;
    logic [bdlp_pkg::CNT_W-1:0]       db_load;
    logic                             dec_zero;

    assign cnt_dec  = cnt_reg - {{(bdlp_pkg::CNT_W-1){1'b0}}, 1'b1};
    assign dec_zero = (cnt_dec == '0);
    assign db_load  = {{(bdlp_pkg::CNT_W-bdlp_pkg::DB_W){1'b0}}, cfg.debounce_ticks};

    // Next phase and counter
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (phase_reg)
            bdlp_pkg::PH_IDLE:
            begin
                if (!released)
                begin
                    phase_next = bdlp_pkg::PH_PRESS_DB;
                    cnt_next   = db_load;
                end
            end
            bdlp_pkg::PH_PRESS_DB:
            begin
                cnt_next = cnt_dec;
                if (dec_zero)
                begin
                    if (!released)
                    begin
                        phase_next = bdlp_pkg::PH_PRESSED;
                        cnt_next   = cfg.hold_ticks;
                    end
                    else
                    begin
                        phase_next = bdlp_pkg::PH_IDLE;
                    end
                end
            end
            bdlp_pkg::PH_PRESSED:
            begin
                cnt_next = cnt_dec;
                if (released)
                begin
                    phase_next = bdlp_pkg::PH_RELEASE_DB;
                    cnt_next   = db_load;
                end
                else if (dec_zero)
                begin
                    phase_next = bdlp_pkg::PH_HELD;
                end
            end
            bdlp_pkg::PH_HELD:
            begin
                if (released)
                begin
                    phase_next = bdlp_pkg::PH_RELEASE_DB;
                    cnt_next   = db_load;
                end
            end
            bdlp_pkg::PH_RELEASE_DB:
            begin
                cnt_next = cnt_dec;
                if (dec_zero)
                begin
                    phase_next = released ? bdlp_pkg::PH_IDLE : bdlp_pkg::PH_HELD;
                end
            end
            default:
            begin
                phase_next = bdlp_pkg::PH_IDLE;
            end
        endcase
    end

    // Events for this tick
    always_comb
    begin
        ev = '0;
        case (phase_reg)
            bdlp_pkg::PH_PRESS_DB:
            begin
                ev.press = dec_zero && !released;
            end
            bdlp_pkg::PH_PRESSED:
            begin
                ev.hold = dec_zero && !released;
            end
            default:
            begin
                ev = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bdlp_pkg::PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/button_debounce_long_press.sv -----
// Top level of the four-button debouncer with long-press events.
// Depends on bdlp_pkg, bdlp_in_if, bdlp_out_if and bdlp_button.
//
//  port     | dir  | payload                        | handshake
//  ---------+------+--------------------------------+-------------------------
//  scan     | in   | raw_buttons_n [3:0]            | valid/ready
//  result   | out  | press_events, hold_events[3:0] | valid/ready
//  cfg      | in   | cfg_index, cfg_data [15:0]     | cfg_we, no back-pressure
//
// One scan tick is taken into the input register, evaluated by the button
// machines and written to the result register once it is free: one tick per
// cycle while results are taken. The input and result registers part the two
// sides, so a tick is taken into an empty input register while a result waits.
// Reset loads debounce 10 and hold 600 and puts every button in idle.
module button_debounce_long_press (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_data,
    bdlp_in_if.sink                          scan,
    bdlp_out_if.source                       result
);

    bdlp_pkg::cfg_t                    cfg_reg;
    logic                              scan_valid_reg;
    logic [bdlp_pkg::IO_BITS-1:0]      raw_reg;
    logic                              res_valid_reg;
    logic [bdlp_pkg::IO_BITS-1:0]      press_reg;
    logic [bdlp_pkg::IO_BITS-1:0]      hold_reg;
    logic [bdlp_pkg::IO_BITS-1:0]      press_next;
    logic [bdlp_pkg::IO_BITS-1:0]      hold_next;
    logic                              advance;
    logic                              scan_take;
    bdlp_pkg::btn_ev_t                 ev [bdlp_pkg::NUM_BUTTONS];

    assign advance   = scan_valid_reg && (!res_valid_reg || result.ready);
    assign scan.ready = !scan_valid_reg || advance;
    assign scan_take = scan.valid && scan.ready;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= bdlp_pkg::DEBOUNCE_RESET;
            cfg_reg.hold_ticks     <= bdlp_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdlp_pkg::REG_DEBOUNCE:
                begin
                    cfg_reg.debounce_ticks <= cfg_data[bdlp_pkg::DB_W-1:0];
                end
                bdlp_pkg::REG_HOLD:
                begin
                    cfg_reg.hold_ticks <= cfg_data[bdlp_pkg::HOLD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
        end
        else if (scan_take)
        begin
            scan_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            scan_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            raw_reg <= scan.raw_buttons_n;
        end
    end

    genvar b;
    generate
        for (b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
        begin : g_btn
            logic released;
            if (b < bdlp_pkg::IO_BITS)
            begin : g_io
                assign released = raw_reg[b];
            end
            else
            begin : g_noio
                // no input pin: reads released
                assign released = 1'b1;
            end
            bdlp_button u_btn (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .released (released),
                .cfg      (cfg_reg),
                .ev       (ev[b])
            );
        end

        for (b = 0; b < bdlp_pkg::IO_BITS; b++)
        begin : g_out
            if (b < bdlp_pkg::NUM_BUTTONS)
            begin : g_ev
                assign press_next[b] = ev[b].press;
                assign hold_next[b]  = ev[b].hold;
            end
            else
            begin : g_zero
                assign press_next[b] = 1'b0;
                assign hold_next[b]  = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            press_reg <= press_next;
            hold_reg  <= hold_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.press_events = press_reg;
    assign result.hold_events  = hold_reg;

    // A button never reports press and hold in the same tick
    a_no_dual_event: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((press_reg & hold_reg) == '0))
        else $error("press and hold on the same button in one tick");

    // A held tick is never lost
    a_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_valid_reg && !advance) |=> scan_valid_reg)
        else $error("pending tick dropped");

    // An evaluated tick always yields a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("evaluated tick produced no result");

    // Full input stage with a stalled result takes no new request
    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_valid_reg && res_valid_reg && !result.ready) |-> !scan.ready)
        else $error("request taken while both stages are full");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for button_debounce_long_press: scan ticks in, press and
// hold event vectors out, checked against a per-button phase predictor or typed events.
// Depends on bdlp_pkg, bdlp_in_if, bdlp_out_if and the RTL top level.
module testbench;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_ROWS    = 28;
    localparam int PHASE_ITEMS = 220;

    localparam logic [bdlp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [bdlp_pkg::IO_BITS-1:0] press;
        logic [bdlp_pkg::IO_BITS-1:0] hold;
    } tick_events_t;

    typedef enum logic {ROW_SCAN, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [bdlp_pkg::IO_BITS-1:0]       raw;
        logic [19:0]                        reps;
        logic                               checked;
        tick_events_t                       ev;
        logic [bdlp_pkg::CFG_IDX_W-1:0]     reg_index;
        logic [bdlp_pkg::CFG_DATA_W-1:0]    reg_data;
    } directed_row_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [bdlp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [bdlp_pkg::CFG_DATA_W-1:0]    cfg_data;

    bdlp_in_if  scan_if ();
    bdlp_out_if result_if ();

    button_debounce_long_press u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_if),
        .result    (result_if)
    );

    // Predictor state and settings
    bdlp_pkg::phase_t                   btn_phase [bdlp_pkg::NUM_BUTTONS];
    logic [bdlp_pkg::CNT_W-1:0]         btn_count [bdlp_pkg::NUM_BUTTONS];
    logic [bdlp_pkg::DB_W-1:0]          debounce_setting;
    logic [bdlp_pkg::HOLD_W-1:0]        hold_setting;

    // Random level generator, one run per button
    logic                btn_level    [bdlp_pkg::NUM_BUTTONS];
    int                  btn_run_left [bdlp_pkg::NUM_BUTTONS];

    tick_events_t        pending_events [$];
    directed_row_t       directed_rows [NUM_ROWS];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  src_pct = 0;
    int                  sink_pct = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic tick_events_t step_buttons(input logic [bdlp_pkg::IO_BITS-1:0] raw);
        tick_events_t                   ev;
        logic                           released;
        logic [bdlp_pkg::CNT_W-1:0]     cnt;
        ev = '0;
        for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
        begin
            released = (b < bdlp_pkg::IO_BITS) ? raw[b] : 1'b1;
            cnt = btn_count[b];
            case (btn_phase[b])
                bdlp_pkg::PH_IDLE:
                begin
                    if (!released)
                    begin
                        btn_phase[b] = bdlp_pkg::PH_PRESS_DB;
                        cnt = bdlp_pkg::CNT_W'(debounce_setting);
                    end
                end
                bdlp_pkg::PH_PRESS_DB:
                begin
                    cnt = cnt - 1'b1;
                    if (cnt == '0)
                    begin
                        if (!released)
                        begin
                            btn_phase[b] = bdlp_pkg::PH_PRESSED;
                            cnt = bdlp_pkg::CNT_W'(hold_setting);
                            if (b < bdlp_pkg::IO_BITS)
                                ev.press[b] = 1'b1;
                        end
                        else
                            btn_phase[b] = bdlp_pkg::PH_IDLE;
                    end
                end
                bdlp_pkg::PH_PRESSED:
                begin
                    cnt = cnt - 1'b1;
                    if (released)
                    begin
                        btn_phase[b] = bdlp_pkg::PH_RELEASE_DB;
                        cnt = bdlp_pkg::CNT_W'(debounce_setting);
                    end
                    else if (cnt == '0)
                    begin
                        btn_phase[b] = bdlp_pkg::PH_HELD;
                        if (b < bdlp_pkg::IO_BITS)
                            ev.hold[b] = 1'b1;
                    end
                end
                bdlp_pkg::PH_HELD:
                begin
                    if (released)
                    begin
                        btn_phase[b] = bdlp_pkg::PH_RELEASE_DB;
                        cnt = bdlp_pkg::CNT_W'(debounce_setting);
                    end
                end
                bdlp_pkg::PH_RELEASE_DB:
                begin
                    cnt = cnt - 1'b1;
                    if (cnt == '0)
                        btn_phase[b] = released ? bdlp_pkg::PH_IDLE : bdlp_pkg::PH_HELD;
                end
                default:
                    btn_phase[b] = bdlp_pkg::PH_IDLE;
            endcase
            btn_count[b] = cnt;
        end
        return ev;
    endfunction

    function automatic directed_row_t scan_ticks(input logic [bdlp_pkg::IO_BITS-1:0] raw,
                                                 input int reps);
        directed_row_t r;
        r = '0;
        r.kind = ROW_SCAN;
        r.raw = raw;
        r.reps = 20'(reps);
        return r;
    endfunction

    function automatic directed_row_t scan_checked(input logic [bdlp_pkg::IO_BITS-1:0] raw,
                                                   input logic [bdlp_pkg::IO_BITS-1:0] press,
                                                   input logic [bdlp_pkg::IO_BITS-1:0] hold);
        directed_row_t r;
        r = scan_ticks(raw, 1);
        r.checked = 1'b1;
        r.ev.press = press;
        r.ev.hold = hold;
        return r;
    endfunction

    function automatic directed_row_t reg_write_row(
        input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
        input logic [bdlp_pkg::CFG_DATA_W-1:0] data);
        directed_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_index = idx;
        r.reg_data = data;
        return r;
    endfunction

    task automatic send_scan(input logic [bdlp_pkg::IO_BITS-1:0] raw, input logic checked,
                             input tick_events_t typed_ev);
        tick_events_t predicted;
        while ($urandom_range(99) < src_pct)
        begin
            scan_if.valid <= 1'b0;
            @(posedge clk);
        end
        scan_if.valid <= 1'b1;
        scan_if.raw_buttons_n <= raw;
        @(posedge clk);
        while (!scan_if.ready)
            @(posedge clk);
        // Advance the predictor even where the expectation is typed in
        predicted = step_buttons(raw);
        pending_events.push_back(checked ? typed_ev : predicted);
    endtask

    task automatic wait_idle();
        scan_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdlp_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == bdlp_pkg::REG_DEBOUNCE)
            debounce_setting = data[bdlp_pkg::DB_W-1:0];
        else if (idx == bdlp_pkg::REG_HOLD)
            hold_setting = data[bdlp_pkg::HOLD_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random_phase(input int deb, input int hold, input idle_mode_t mode,
                                    input int items);
        int                             span;
        logic [bdlp_pkg::IO_BITS-1:0]   raw;
        wait_idle();
        write_reg(bdlp_pkg::REG_DEBOUNCE, bdlp_pkg::CFG_DATA_W'(deb));
        write_reg(bdlp_pkg::REG_HOLD, bdlp_pkg::CFG_DATA_W'(hold));
        span = 2 * deb + hold + 4;
        if (span > 600)
            span = 600;
        src_pct = (mode == IDLE_SENDER) ? 69 : (mode == IDLE_BOTH) ? 18 : 0;
        sink_pct = (mode == IDLE_RECEIVER) ? 69 : (mode == IDLE_BOTH) ? 18 : 0;
        for (int n = 0; n < items; n++)
        begin
            // Mostly clean runs long enough to confirm and hold, with short
            // runs and one-tick glitches to break the debounce
            for (int b = 0; b < bdlp_pkg::IO_BITS; b++)
            begin
                if (btn_run_left[b] == 0)
                begin
                    btn_level[b] = ~btn_level[b];
                    btn_run_left[b] = ($urandom_range(3) == 0) ? $urandom_range(deb + 1, 1)
                                                              : $urandom_range(span, 1);
                end
                raw[b] = btn_level[b] ^ ($urandom_range(11) == 0);
                btn_run_left[b]--;
            end
            if ($urandom_range(9) == 0)
                raw = bdlp_pkg::IO_BITS'($urandom_range(15));
            send_scan(raw, 1'b0, '0);
        end
    endtask

    // Result side: check each accepted result, then pick ready for the next cycle
    initial
    begin
        tick_events_t want;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("result with no request pending: press_events=%h hold_events=%h",
                           result_if.press_events, result_if.hold_events);
                    error_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (result_if.press_events !== want.press)
                    begin
                        $error("press_events: expected %h, got %h",
                               want.press, result_if.press_events);
                        error_count++;
                    end
                    if (result_if.hold_events !== want.hold)
                    begin
                        $error("hold_events: expected %h, got %h",
                               want.hold, result_if.hold_events);
                        error_count++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(99) >= sink_pct);
        end
    end

    initial
    begin
        directed_row_t row;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bdlp_pkg::REG_DEBOUNCE;
        cfg_data <= '0;
        scan_if.valid <= 1'b0;
        scan_if.raw_buttons_n <= '1;

        debounce_setting = bdlp_pkg::DEBOUNCE_RESET;
        hold_setting = bdlp_pkg::HOLD_RESET;
        for (int b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
        begin
            btn_phase[b] = bdlp_pkg::PH_IDLE;
            btn_count[b] = '0;
            btn_level[b] = 1'b1;
            btn_run_left[b] = 0;
        end

        directed_rows = '{
            // reset settings: debounce 10, hold 600
            scan_checked(4'hF, 4'h0, 4'h0),
            scan_ticks(4'hE, 10),
            scan_checked(4'hE, 4'h1, 4'h0),
            scan_ticks(4'hE, 599),
            scan_checked(4'hE, 4'h0, 4'h1),
            scan_ticks(4'hF, 11),
            // press too short to confirm
            scan_ticks(4'hD, 3),
            scan_ticks(4'hF, 10),
            scan_ticks(4'h0, 10),
            scan_checked(4'h0, 4'hF, 4'h0),
            // release bounce while pressed falls back to held
            scan_ticks(4'h5, 1),
            scan_ticks(4'h0, 12),
            scan_ticks(4'hF, 15),
            // write to an unmapped index leaves debounce at 10
            reg_write_row(REG_UNMAPPED, 16'hFFFF),
            scan_ticks(4'hE, 10),
            scan_checked(4'hE, 4'h1, 4'h0),
            scan_ticks(4'hF, 12),
            // shortest counts
            reg_write_row(bdlp_pkg::REG_DEBOUNCE, 16'd1),
            reg_write_row(bdlp_pkg::REG_HOLD, 16'd1),
            scan_ticks(4'h7, 1),
            scan_checked(4'h7, 4'h8, 4'h0),
            scan_checked(4'h7, 4'h0, 4'h8),
            scan_ticks(4'hF, 2),
            // zero hold count wraps, so no hold event follows the press at once
            reg_write_row(bdlp_pkg::REG_HOLD, 16'd0),
            scan_ticks(4'hE, 1),
            scan_checked(4'hE, 4'h1, 4'h0),
            scan_checked(4'hE, 4'h0, 4'h0),
            scan_ticks(4'hF, 2)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                wait_idle();
                write_reg(row.reg_index, row.reg_data);
            end
            else
            begin
                for (int k = 0; k < int'(row.reps); k++)
                    send_scan(row.raw, row.checked, row.ev);
            end
        end

        run_random_phase(1, 1, IDLE_NONE, PHASE_ITEMS);
        run_random_phase(3, 12, IDLE_SENDER, PHASE_ITEMS);
        run_random_phase(255, 65535, IDLE_RECEIVER, PHASE_ITEMS);
        run_random_phase(2, 20, IDLE_BOTH, PHASE_ITEMS);
        run_random_phase(5, 7, IDLE_SENDER, PHASE_ITEMS);
        run_random_phase($urandom_range(8, 1), $urandom_range(40, 1), IDLE_RECEIVER,
                         PHASE_ITEMS);

        wait_idle();
        // keep the clock running to catch any stray result
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
